/* rtl/dojq_pkg.sv */
`timescale 1ns / 1ps

package dojq_pkg;

    localparam int TIME_W  = 48;
    localparam int WAIT_W  = 32;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_RELEASED = 2'd2,
        KIND_NONE_DUE = 2'd3
    } kind_t;

    typedef enum logic {
        FUNC_SCHEDULE = 1'b0,
        FUNC_SERVICE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_SERVE
    } state_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

/* rtl/dojq_cell.sv */
`timescale 1ns / 1ps

module dojq_cell #(
    parameter int TAG_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dojq_pkg::cell_ctrl_t        ctrl,
    input  logic [dojq_pkg::TIME_W-1:0] key,
    input  logic [dojq_pkg::TIME_W-1:0] new_deadline,
    input  logic [TAG_BITS-1:0]         new_tag,
    input  logic                        prev_valid,
    input  logic                        prev_le,
    input  logic [dojq_pkg::TIME_W-1:0] prev_deadline,
    input  logic [TAG_BITS-1:0]         prev_tag,
    input  logic                        next_valid,
    input  logic [dojq_pkg::TIME_W-1:0] next_deadline,
    input  logic [TAG_BITS-1:0]         next_tag,
    output logic                        valid,
    output logic                        le,
    output logic [dojq_pkg::TIME_W-1:0] deadline,
    output logic [TAG_BITS-1:0]         tag
);
    import dojq_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [TIME_W-1:0]   deadline_reg;
    logic [TIME_W-1:0]   deadline_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // held entry sits at or before the key
    assign le = valid_reg && (deadline_reg <= key);

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        if (ctrl.pop)
        begin
            valid_next    = next_valid;
            deadline_next = next_deadline;
            tag_next      = next_tag;
        end
        else if (ctrl.insert && !le)
        begin
            if (prev_le)
            begin
                valid_next    = 1'b1;
                deadline_next = new_deadline;
                tag_next      = new_tag;
            end
            else
            begin
                valid_next    = prev_valid;
                deadline_next = prev_deadline;
                tag_next      = prev_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
    end

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign tag      = tag_reg;

endmodule

/* rtl/deadline_ordered_job_queue_unit.sv */
`timescale 1ns / 1ps

// Deadline-ordered job queue: a row of QUEUE_DEPTH cells holds pending jobs
// sorted by deadline, earliest in cell 0, equal deadlines in arrival order.
// A schedule request (func 0) registers now_time + wait_time (saturating at
// 2^48-1); then, once the result side is free, every cell compares its
// deadline to the new one in parallel and the row shifts right by one
// behind the insertion point, giving one accepted or queue-full result. A
// service request (func 1) registers now_time and then releases one due job
// per cycle from cell 0 while the result side accepts and the row shifts
// left, or gives a single nothing-due result if cell 0 holds no due job.
// The last result of each request has last_of_run set; every result carries
// the count left pending. One request is in flight at a time; results wait
// in an output register, and a stalled result side stalls the row.
module deadline_ordered_job_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         func,
    input  logic [TAG_BITS-1:0]          job_tag,
    input  logic [dojq_pkg::WAIT_W-1:0]  wait_time,
    input  logic [dojq_pkg::TIME_W-1:0]  now_time,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [dojq_pkg::KIND_W-1:0]  kind,
    output logic [TAG_BITS-1:0]          out_tag,
    output logic [dojq_pkg::TIME_W-1:0]  deadline,
    output logic                         last_of_run,
    output logic                         queue_empty,
    output logic [dojq_pkg::COUNT_W-1:0] pending_count
);
    import dojq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg;
    state_t              state_next;

    // request registers
    logic [TIME_W-1:0]   dl_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TIME_W:0]     dl_sum;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // output register
    logic                res_valid_reg;
    kind_t               kind_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    res_count_reg;

    logic                req_fire;
    logic                slot_free;
    logic                full;
    logic                head_due;
    logic                more_due;
    cell_ctrl_t          ctrl;
    logic                emit;
    kind_t               emit_kind;
    logic [TAG_BITS-1:0] emit_tag;
    logic [TIME_W-1:0]   emit_deadline;
    logic                emit_last;
    logic [TIME_W-1:0]   key;

    // cell row
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_le;
    logic [TIME_W-1:0]      cell_dl  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    cell_tag [QUEUE_DEPTH];

    assign req_fire  = req_valid && req_ready;
    assign slot_free = !res_valid_reg || res_ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_due  = cell_le[0];
    assign more_due  = cell_le[1];
    // the same comparator serves insertion search and due test
    assign key       = (state_reg == ST_SCHED) ? dl_reg : now_reg;
    assign dl_sum    = {1'b0, now_time} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_time};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                prev_valid;
            logic                prev_le;
            logic [TIME_W-1:0]   prev_deadline;
            logic [TAG_BITS-1:0] prev_tag;
            logic                next_valid;
            logic [TIME_W-1:0]   next_deadline;
            logic [TAG_BITS-1:0] next_tag;

            if (gi == 0)
            begin : g_head
                assign prev_valid    = 1'b1;
                assign prev_le       = 1'b1;
                assign prev_deadline = dl_reg;
                assign prev_tag      = tag_reg;
            end
            else
            begin : g_body
                assign prev_valid    = cell_valid[gi-1];
                assign prev_le       = cell_le[gi-1];
                assign prev_deadline = cell_dl[gi-1];
                assign prev_tag      = cell_tag[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_valid    = 1'b0;
                assign next_deadline = cell_dl[gi];
                assign next_tag      = cell_tag[gi];
            end
            else
            begin : g_inner
                assign next_valid    = cell_valid[gi+1];
                assign next_deadline = cell_dl[gi+1];
                assign next_tag      = cell_tag[gi+1];
            end

            dojq_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .key           (key),
                .new_deadline  (dl_reg),
                .new_tag       (tag_reg),
                .prev_valid    (prev_valid),
                .prev_le       (prev_le),
                .prev_deadline (prev_deadline),
                .prev_tag      (prev_tag),
                .next_valid    (next_valid),
                .next_deadline (next_deadline),
                .next_tag      (next_tag),
                .valid         (cell_valid[gi]),
                .le            (cell_le[gi]),
                .deadline      (cell_dl[gi]),
                .tag           (cell_tag[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (func == FUNC_SERVICE) ? ST_SERVE : ST_SCHED;
                end
            end
            ST_SCHED:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SERVE:
            begin
                if (slot_free && !(head_due && more_due))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready     = 1'b0;
        ctrl          = '0;
        emit          = 1'b0;
        emit_kind     = KIND_NONE_DUE;
        emit_tag      = '0;
        emit_deadline = '0;
        emit_last     = 1'b1;
        count_next    = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_SCHED:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    emit_tag      = tag_reg;
                    emit_deadline = dl_reg;
                    if (full)
                    begin
                        emit_kind = KIND_REJECTED;
                    end
                    else
                    begin
                        emit_kind   = KIND_ACCEPTED;
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            ST_SERVE:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (head_due)
                    begin
                        emit_kind     = KIND_RELEASED;
                        emit_tag      = cell_tag[0];
                        emit_deadline = cell_dl[0];
                        emit_last     = !more_due;
                        ctrl.pop      = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            dl_reg  <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
            now_reg <= now_time;
            tag_reg <= job_tag;
        end
        if (emit)
        begin
            kind_reg      <= emit_kind;
            out_tag_reg   <= emit_tag;
            deadline_reg  <= emit_deadline;
            last_reg      <= emit_last;
            res_count_reg <= count_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign kind          = kind_reg;
    assign out_tag       = out_tag_reg;
    assign deadline      = deadline_reg;
    assign last_of_run   = last_reg;
    assign queue_empty   = (res_count_reg == '0);
    assign pending_count = COUNT_W'(res_count_reg);

    // the occupancy count tracks the valid cells
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(cell_valid)))
        else $error("pending count differs from occupied cells");

    // a full row never takes an insert
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |-> !full)
        else $error("insert into a full queue");

    // release only from an occupied head, and the count drops by one
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> cell_valid[0] ##1 (count_reg == $past(count_reg) - 1'b1))
        else $error("release from empty head or count not updated");

    // the row stays packed at the head: cell 1 is never occupied while cell 0 is empty
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> cell_valid[0])
        else $error("hole at the head of the queue");

endmodule
